FILE: hdl/immr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// immr_pkg
// Shared types and constants for the interrupt mode/mask register block.
// ----------------------------------------------------------------------------
package immr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 10;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned SRC_N  = 6;
  localparam int unsigned WD_USE = 14;   // write data bits 13:0 carry meaning

  localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0202_0102;

  // Request codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_READ  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_EVENT = 2'd2;

  // Register select, offset bits 3:2
  typedef enum logic [1:0] {
    SEL_MODE    = 2'd0,
    SEL_VERSION = 2'd1,
    SEL_PENDING = 2'd2,
    SEL_MASK    = 2'd3
  } sel_t;

  // Mode write data bit positions
  localparam int unsigned MW_CLR_F7   = 7;
  localparam int unsigned MW_SET_F7   = 8;
  localparam int unsigned MW_CLR_F8   = 9;
  localparam int unsigned MW_SET_F8   = 10;
  localparam int unsigned MW_CLR_PND5 = 11;
  localparam int unsigned MW_CLR_F9   = 12;
  localparam int unsigned MW_SET_F9   = 13;

  // Flag bit positions inside the mode register
  localparam int unsigned MODE_F7 = 7;
  localparam int unsigned MODE_F8 = 8;
  localparam int unsigned MODE_F9 = 9;

  // Source whose pending bit a mode write may clear
  localparam int unsigned PND_CLR_SRC = 5;

endpackage

FILE: hdl/interrupt_mode_mask_registers_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_mode_mask_registers_unit
// Mode register, six pending bits and six mask bits behind a request port.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_ready  | cmd, reg_offset, write_data,
//          |           |                    | source_id, source_level
//  out_    | output    | out_valid/out_ready| read_data, pending_bits, mask_bits
//
//  - One request per cycle sustained while out_ready stays high. A request
//    passes the input register, then the result register, before out_valid
//    rises; a stall on out_ready holds it in the input register.
//  - State (mode, pending, mask) updates as a request moves from the input
//    register to the result register, so requests are applied in order.
//  - The input register keeps taking a request while a result waits on
//    out_ready; only when both stages are full does in_ready drop.
//  - rst_n is synchronous, active low; it clears both valid flags and all
//    three state registers.
//
module interrupt_mode_mask_registers_unit
  import immr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [3:0]          in_reg_offset,
  input  logic [DATA_W-1:0]   in_write_data,
  input  logic [2:0]          in_source_id,
  input  logic                in_source_level,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [SRC_N-1:0]    out_pending_bits,
  output logic [SRC_N-1:0]    out_mask_bits
);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              in_valid_r;
  cmd_t              cmd_r;
  sel_t              sel_r;
  logic [WD_USE-1:0] wdata_r;    // only the low bits of write data matter
  logic [2:0]        src_r;
  logic              lvl_r;

  // --------------------------------------------------------------------------
  // State and result register
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_r,    mode_nxt;
  logic [SRC_N-1:0]  pending_r, pending_nxt;
  logic [SRC_N-1:0]  mask_r,    mask_nxt;
  logic [DATA_W-1:0] rdata_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [SRC_N-1:0]  out_pend_r;
  logic [SRC_N-1:0]  out_mask_r;

  logic out_free;   // result register can take a new value this cycle
  logic advance;    // request moves from input register to result register
  logic in_take;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= in_cmd;
      sel_r   <= sel_t'(in_reg_offset[3:2]);
      wdata_r <= in_write_data[WD_USE-1:0];
      src_r   <= in_source_id;
      lvl_r   <= in_source_level;
    end
  end

  // --------------------------------------------------------------------------
  // Request decode and state update
  // --------------------------------------------------------------------------
  always_comb begin
    mode_nxt    = mode_r;
    pending_nxt = pending_r;
    mask_nxt    = mask_r;
    rdata_nxt   = '0;

    unique case (cmd_r)
      CMD_READ: begin
        unique case (sel_r)
          SEL_MODE:    rdata_nxt = {{(DATA_W-MODE_W){1'b0}}, mode_r};
          SEL_VERSION: rdata_nxt = VERSION_WORD;
          SEL_PENDING: rdata_nxt = {{(DATA_W-SRC_N){1'b0}}, pending_r};
          SEL_MASK:    rdata_nxt = {{(DATA_W-SRC_N){1'b0}}, mask_r};
        endcase
      end
      CMD_WRITE: begin
        unique case (sel_r)
          SEL_MODE: begin
            // length loads directly; flags are clear/set pairs, set wins
            mode_nxt[LEN_W-1:0] = wdata_r[LEN_W-1:0];
            mode_nxt[MODE_F7] = wdata_r[MW_SET_F7] |
                                (mode_r[MODE_F7] & ~wdata_r[MW_CLR_F7]);
            mode_nxt[MODE_F8] = wdata_r[MW_SET_F8] |
                                (mode_r[MODE_F8] & ~wdata_r[MW_CLR_F8]);
            mode_nxt[MODE_F9] = wdata_r[MW_SET_F9] |
                                (mode_r[MODE_F9] & ~wdata_r[MW_CLR_F9]);
            if (wdata_r[MW_CLR_PND5]) begin
              pending_nxt[PND_CLR_SRC] = 1'b0;
            end
          end
          SEL_MASK: begin
            for (int s = 0; s < SRC_N; s++) begin
              mask_nxt[s] = wdata_r[2*s+1] | (mask_r[s] & ~wdata_r[2*s]);
            end
          end
          SEL_VERSION, SEL_PENDING: ;   // read-only, write dropped
        endcase
      end
      CMD_EVENT: begin
        // sources six and seven do not exist
        if (src_r < 3'(SRC_N)) begin
          pending_nxt[src_r] = lvl_r;
        end
      end
      default: ;                        // unused code: no effect, reads zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      pending_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        mode_r    <= mode_nxt;
        pending_r <= pending_nxt;
        mask_r    <= mask_nxt;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rdata_r <= rdata_nxt;
      out_pend_r  <= pending_nxt;
      out_mask_r  <= mask_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rdata_r;
  assign out_pending_bits = out_pend_r;
  assign out_mask_bits    = out_mask_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(mode_r) && $stable(pending_r) && $stable(mask_r))
    else $error("state changed without a request moving");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pend_r == pending_r) && (out_mask_r == mask_r))
    else $error("pending/mask result differs from state");

  a_version_read: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd_r == CMD_READ && sel_r == SEL_VERSION
    |=> out_rdata_r == VERSION_WORD)
    else $error("version read returned wrong word");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd_r != CMD_READ |=> out_rdata_r == '0)
    else $error("non-read request returned nonzero read data");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

endmodule
